// ===== rtl/core/apd_pkg.sv =====
// shared types and constants for the avro primitive decoder
package apd_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned RKIND_W = 3;
  localparam int unsigned BPOS_W  = 4;
  localparam int unsigned PLEFT_W = 63;

  localparam logic [BPOS_W-1:0] INT_VARINT_BYTES  = 4'd5;
  localparam logic [BPOS_W-1:0] LONG_VARINT_BYTES = 4'd10;
  localparam logic [BPOS_W-1:0] FLOAT_BYTES       = 4'd4;
  localparam logic [BPOS_W-1:0] DOUBLE_BYTES      = 4'd8;

  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned CONT_IDX   = 7;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_VARINT  = 2'd1,
    PH_FIXED   = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef enum logic [REQ_W-1:0] {
    K_LONG   = 3'd0,
    K_INT    = 3'd1,
    K_RAW    = 3'd2,
    K_FLOAT  = 3'd3,
    K_DOUBLE = 3'd4,
    K_BOOL   = 3'd5,
    K_STRING = 3'd6
  } kind_t;

  typedef enum logic [RKIND_W-1:0] {
    R_VALUE   = 3'd0,
    R_LENGTH  = 3'd1,
    R_PAYLOAD = 3'd2,
    R_TOOLONG = 3'd3,
    R_NEGLEN  = 3'd4
  } res_kind_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    res_kind_t          result_kind;
    logic               last;
  } result_t;

endpackage

// ===== rtl/core/apd_in_if.sv =====
// input byte channel: valid/ready with data byte and requested value kind
interface apd_in_if
  import apd_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [DATA_W-1:0] data_byte;
  logic [REQ_W-1:0]  req_type;

  modport source (output valid, output data_byte, output req_type, input ready);
  modport sink   (input valid, input data_byte, input req_type, output ready);
endinterface

// ===== rtl/core/apd_out_if.sv =====
// result channel: valid/ready with decoded value, result kind and last flag
interface apd_out_if
  import apd_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_bits;
  logic [RKIND_W-1:0] result_kind;
  logic               last;

  modport source (output valid, output value_bits, output result_kind, output last,
                  input ready);
  modport sink   (input valid, input value_bits, input result_kind, input last,
                  output ready);
endinterface

// ===== rtl/core/avro_primitive_decoder.sv =====
// Byte-serial decoder for avro binary primitives (zigzag long/int, raw varint,
// float/double bit patterns, boolean, string/bytes length and payload). One byte
// is taken per clock cycle while ready is high. The decode state (accumulator,
// byte position, payload count) and the result register on the accepting edge,
// the result into the output register or, while it stalls, the one skid entry.
// That two-entry buffer lets the input keep running for one beat while the result
// side stalls; ready drops only while the skid entry holds a result. Bytes that
// end no value give no result. An overlong varint or a negative string length
// gives an error result with last set and the decoder returns to idle.
module avro_primitive_decoder
  import apd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  apd_in_if.sink    in_if,
  apd_out_if.source out_if
);

  // decode state
  phase_t              phase_r,     phase_nxt;
  kind_t               held_kind_r, held_kind_nxt;
  logic [VALUE_W-1:0]  acc_r,       acc_nxt;
  logic [BPOS_W-1:0]   bpos_r,      bpos_nxt;
  logic [PLEFT_W-1:0]  pleft_r,     pleft_nxt;

  // output buffer
  logic    out_valid_r, skid_valid_r;
  result_t out_res_r, skid_res_r;

  logic in_fire, out_take, has_res;
  result_t res;

  // state seen by this beat, after a value start is folded in
  phase_t             cur_phase;
  kind_t              cur_kind, req_kind;
  logic               start_ok;
  logic [VALUE_W-1:0] cur_acc;
  logic [BPOS_W-1:0]  cur_bpos;

  // working values
  logic [5:0]         vshift;
  logic [VALUE_W-1:0] vacc, facc, zz, int_val;
  logic [31:0]        z32;
  logic [BPOS_W-1:0]  bpos_inc, vlimit, flimit;
  logic               cont;

  assign in_if.ready = !skid_valid_r;
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_take    = out_valid_r && out_if.ready;

  assign out_if.valid       = out_valid_r;
  assign out_if.value_bits  = out_res_r.value_bits;
  assign out_if.result_kind = out_res_r.result_kind;
  assign out_if.last        = out_res_r.last;

  assign req_kind = kind_t'(in_if.req_type);

  always_comb begin
    start_ok  = 1'b1;
    cur_phase = phase_r;
    cur_kind  = held_kind_r;
    cur_acc   = acc_r;
    cur_bpos  = bpos_r;
    if (phase_r == PH_IDLE) begin
      cur_kind = req_kind;
      cur_acc  = '0;
      cur_bpos = '0;
      unique case (req_kind)
        K_LONG, K_INT, K_RAW, K_STRING: cur_phase = PH_VARINT;
        K_FLOAT, K_DOUBLE:              cur_phase = PH_FIXED;
        K_BOOL:                         cur_phase = PH_IDLE;
        default:                        start_ok  = 1'b0;
      endcase
    end
  end

  always_comb begin
    cont     = in_if.data_byte[CONT_IDX];
    bpos_inc = cur_bpos + 4'd1;
    vlimit   = (cur_kind == K_INT) ? INT_VARINT_BYTES : LONG_VARINT_BYTES;
    flimit   = (cur_kind == K_FLOAT) ? FLOAT_BYTES : DOUBLE_BYTES;

    // 7-bit group, least significant first; bit 63 keeps only the group's low bit
    vshift = 6'(cur_bpos) * 6'd7;
    vacc   = cur_acc | (VALUE_W'(in_if.data_byte[GROUP_BITS-1:0]) << vshift);
    if (cur_kind == K_INT) begin
      vacc[VALUE_W-1:32] = '0;
    end
    zz      = (vacc >> 1) ^ {VALUE_W{vacc[0]}};
    z32     = (vacc[31:0] >> 1) ^ {32{vacc[0]}};
    int_val = {{32{z32[31]}}, z32};

    facc = cur_acc | (VALUE_W'(in_if.data_byte) << {cur_bpos[2:0], 3'b000});
  end

  always_comb begin
    phase_nxt     = cur_phase;
    held_kind_nxt = start_ok ? cur_kind : held_kind_r;
    acc_nxt       = cur_acc;
    bpos_nxt      = cur_bpos;
    pleft_nxt     = pleft_r;
    has_res       = 1'b0;
    res           = '{value_bits: '0, result_kind: R_VALUE, last: 1'b1};

    unique case (cur_phase)
      PH_IDLE: begin
        // only a boolean start (or an unknown kind) stays here
        if (start_ok) begin
          has_res        = 1'b1;
          res.value_bits = VALUE_W'(in_if.data_byte == 8'd1);
        end
      end
      PH_VARINT: begin
        acc_nxt  = vacc;
        bpos_nxt = bpos_inc;
        if (cont) begin
          if (bpos_inc >= vlimit) begin
            phase_nxt       = PH_IDLE;
            acc_nxt         = '0;
            bpos_nxt        = '0;
            has_res         = 1'b1;
            res.result_kind = R_TOOLONG;
          end
        end else begin
          phase_nxt = PH_IDLE;
          acc_nxt   = '0;
          bpos_nxt  = '0;
          has_res   = 1'b1;
          unique case (cur_kind)
            K_INT:   res.value_bits = int_val;
            K_RAW:   res.value_bits = vacc;
            K_STRING: begin
              if (zz[VALUE_W-1]) begin
                res.result_kind = R_NEGLEN;
              end else begin
                res.result_kind = R_LENGTH;
                res.value_bits  = zz;
                if (zz != '0) begin
                  res.last  = 1'b0;
                  pleft_nxt = zz[PLEFT_W-1:0];
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
            default: res.value_bits = zz;
          endcase
        end
      end
      PH_FIXED: begin
        acc_nxt  = facc;
        bpos_nxt = bpos_inc;
        if (bpos_inc >= flimit) begin
          phase_nxt      = PH_IDLE;
          acc_nxt        = '0;
          bpos_nxt       = '0;
          has_res        = 1'b1;
          res.value_bits = facc;
        end
      end
      PH_PAYLOAD: begin
        if (pleft_r != '0) begin
          pleft_nxt = pleft_r - 63'd1;
        end
        has_res         = 1'b1;
        res.result_kind = R_PAYLOAD;
        res.value_bits  = VALUE_W'(in_if.data_byte);
        res.last        = 1'b0;
        if (pleft_nxt == '0) begin
          res.last  = 1'b1;
          phase_nxt = PH_IDLE;
          acc_nxt   = '0;
          bpos_nxt  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      held_kind_r <= K_LONG;
      acc_r       <= '0;
      bpos_r      <= '0;
      pleft_r     <= '0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      held_kind_r <= held_kind_nxt;
      acc_r       <= acc_nxt;
      bpos_r      <= bpos_nxt;
      pleft_r     <= pleft_nxt;
    end
  end

  // output register plus skid entry, skid drains first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire && has_res;
      end
    end else if (in_fire && has_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end else if (in_fire && has_res) begin
      skid_res_r <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a beat while the output register is empty");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (pleft_r != '0))
    else $error("payload phase with no bytes left");

  a_varint_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_VARINT) |->
      (bpos_r < ((held_kind_r == K_INT) ? INT_VARINT_BYTES : LONG_VARINT_BYTES)))
    else $error("varint byte position past its limit");

  a_fixed_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FIXED) |-> (held_kind_r == K_FLOAT || held_kind_r == K_DOUBLE))
    else $error("fixed-width phase with a varint kind");

  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.result_kind == R_TOOLONG ||
                     out_res_r.result_kind == R_NEGLEN))
      |-> (out_res_r.last && out_res_r.value_bits == '0))
    else $error("error result without last or with nonzero value");

endmodule

// ===== test/avro_primitive_decoder_test.sv =====
// testbench for avro_primitive_decoder: directed table plus random byte streams
`timescale 1ns / 100ps

module avro_primitive_decoder_test
  import apd_pkg::*;
  ();

  localparam int unsigned DIR_ROWS       = 32;
  localparam int unsigned RANDOM_BEATS   = 360;
  localparam int unsigned LONG_HOLD      = 120;
  localparam int unsigned HOLD_AFTER     = 60;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;

  // how the expected result of a table row is obtained
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_TYPED = 2'd2
  } row_chk_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [REQ_W-1:0]  req;
    row_chk_t          chk;
    result_t           typed;
  } byte_beat_t;

  localparam result_t NO_RES = '{value_bits: '0, result_kind: R_VALUE, last: 1'b0};

  logic clk;
  logic rst_n;

  apd_in_if  in_ch ();
  apd_out_if out_ch ();

  avro_primitive_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // directed beats: typed expectations only where obvious
  byte_beat_t dir_table [0:DIR_ROWS-1] = '{
    '{8'h01, K_BOOL,      CHK_TYPED, '{64'd1, R_VALUE, 1'b1}},
    '{8'hff, K_BOOL,      CHK_TYPED, '{64'd0, R_VALUE, 1'b1}},
    '{8'h55, REQ_UNKNOWN, CHK_NONE,  NO_RES},
    '{8'h00, K_LONG,      CHK_TYPED, '{64'd0, R_VALUE, 1'b1}},
    '{8'h01, K_LONG,      CHK_TYPED, '{64'hffff_ffff_ffff_ffff, R_VALUE, 1'b1}},
    '{8'h7f, K_RAW,       CHK_TYPED, '{64'h7f, R_VALUE, 1'b1}},
    // int whose top group overflows bit 31
    '{8'hff, K_INT,       CHK_MODEL, NO_RES},
    '{8'hff, K_DOUBLE,    CHK_MODEL, NO_RES},
    '{8'hff, REQ_UNKNOWN, CHK_MODEL, NO_RES},
    '{8'hff, K_BOOL,      CHK_MODEL, NO_RES},
    '{8'h7f, K_STRING,    CHK_TYPED, '{64'hffff_ffff_8000_0000, R_VALUE, 1'b1}},
    '{8'h80, K_INT,       CHK_MODEL, NO_RES},
    '{8'h80, K_INT,       CHK_MODEL, NO_RES},
    '{8'h80, K_INT,       CHK_MODEL, NO_RES},
    '{8'h80, K_INT,       CHK_MODEL, NO_RES},
    '{8'h80, K_INT,       CHK_TYPED, '{64'd0, R_TOOLONG, 1'b1}},
    '{8'h00, K_FLOAT,     CHK_MODEL, NO_RES},
    '{8'h00, K_LONG,      CHK_MODEL, NO_RES},
    '{8'h80, K_LONG,      CHK_MODEL, NO_RES},
    '{8'h3f, K_LONG,      CHK_MODEL, NO_RES},
    '{8'hff, K_DOUBLE,    CHK_MODEL, NO_RES},
    '{8'hff, K_DOUBLE,    CHK_MODEL, NO_RES},
    '{8'hff, K_DOUBLE,    CHK_MODEL, NO_RES},
    '{8'hff, K_DOUBLE,    CHK_MODEL, NO_RES},
    '{8'hff, K_DOUBLE,    CHK_MODEL, NO_RES},
    '{8'hff, K_DOUBLE,    CHK_MODEL, NO_RES},
    '{8'hff, K_DOUBLE,    CHK_MODEL, NO_RES},
    '{8'hff, K_DOUBLE,    CHK_TYPED, '{64'hffff_ffff_ffff_ffff, R_VALUE, 1'b1}},
    '{8'h02, K_STRING,    CHK_MODEL, NO_RES},
    '{8'ha5, K_LONG,      CHK_MODEL, NO_RES},
    '{8'h00, K_STRING,    CHK_TYPED, '{64'd0, R_LENGTH, 1'b1}},
    '{8'h01, K_STRING,    CHK_TYPED, '{64'd0, R_NEGLEN, 1'b1}}
  };

  byte_beat_t  stim_q [$];
  byte_beat_t  cur_beat;
  result_t     expected_results [$];
  int unsigned beats_queued;
  int unsigned beats_in = 0;
  int unsigned results_taken = 0;
  int unsigned err_count = 0;
  int unsigned kind_seen [0:4] = '{default: 0};
  bit          feed_done = 1'b0;

  // decoder shadow state
  phase_t               dec_phase;
  kind_t                dec_kind;
  logic [VALUE_W-1:0]   dec_acc;
  logic [BPOS_W-1:0]    dec_pos;
  logic [PLEFT_W-1:0]   dec_left;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    err_count++;
  endtask

  function automatic void back_to_idle();
    dec_phase = PH_IDLE;
    dec_acc   = '0;
    dec_pos   = '0;
  endfunction

  // advance the shadow decoder by one byte; returns 1 when a result is due
  function automatic bit decode_byte(input logic [DATA_W-1:0] b, input logic [REQ_W-1:0] rt,
                                     output result_t res);
    logic [BPOS_W-1:0]  lim;
    int unsigned        shift;
    logic [VALUE_W-1:0] acc;
    logic [VALUE_W-1:0] zz;
    logic [31:0]        a32;
    logic [31:0]        z32;
    res = NO_RES;
    if (dec_phase == PH_IDLE) begin
      if (rt > K_STRING) return 1'b0;
      dec_kind = kind_t'(rt);
      dec_acc  = '0;
      dec_pos  = '0;
      if (dec_kind == K_BOOL) begin
        res = '{{63'd0, b == 8'd1}, R_VALUE, 1'b1};
        return 1'b1;
      end
      dec_phase = (dec_kind == K_FLOAT || dec_kind == K_DOUBLE) ? PH_FIXED : PH_VARINT;
    end
    case (dec_phase)
      PH_VARINT: begin
        lim = (dec_kind == K_INT) ? INT_VARINT_BYTES : LONG_VARINT_BYTES;
        shift = (32'(dec_pos) % 32'(lim)) * GROUP_BITS;
        dec_acc = dec_acc | (64'(b[GROUP_BITS-1:0]) << shift);
        if (dec_kind == K_INT) dec_acc[63:32] = '0;
        dec_pos = dec_pos + 1'b1;
        if (b[CONT_IDX]) begin
          if (dec_pos >= lim) begin
            back_to_idle();
            res = '{64'd0, R_TOOLONG, 1'b1};
            return 1'b1;
          end
          return 1'b0;
        end
        acc = dec_acc;
        zz  = (acc >> 1) ^ {VALUE_W{acc[0]}};
        back_to_idle();
        case (dec_kind)
          K_INT: begin
            a32 = acc[31:0];
            z32 = (a32 >> 1) ^ {32{a32[0]}};
            res = '{{{32{z32[31]}}, z32}, R_VALUE, 1'b1};
          end
          K_RAW: res = '{acc, R_VALUE, 1'b1};
          K_STRING: begin
            if (zz[VALUE_W-1]) begin
              res = '{64'd0, R_NEGLEN, 1'b1};
            end else if (zz == '0) begin
              res = '{64'd0, R_LENGTH, 1'b1};
            end else begin
              dec_left  = zz[PLEFT_W-1:0];
              dec_phase = PH_PAYLOAD;
              res = '{zz, R_LENGTH, 1'b0};
            end
          end
          default: res = '{zz, R_VALUE, 1'b1};
        endcase
        return 1'b1;
      end
      PH_FIXED: begin
        dec_acc = dec_acc | (64'(b) << (32'(dec_pos[2:0]) * 8));
        dec_pos = dec_pos + 1'b1;
        if (dec_pos >= ((dec_kind == K_FLOAT) ? FLOAT_BYTES : DOUBLE_BYTES)) begin
          res = '{dec_acc, R_VALUE, 1'b1};
          back_to_idle();
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (dec_left != '0) dec_left = dec_left - 1'b1;
        if (dec_left == '0) begin
          back_to_idle();
          res = '{{56'd0, b}, R_PAYLOAD, 1'b1};
        end else begin
          res = '{{56'd0, b}, R_PAYLOAD, 1'b0};
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic push_beat(input logic [DATA_W-1:0] b, input logic [REQ_W-1:0] rt);
    byte_beat_t bt;
    bt = '{b, rt, CHK_MODEL, NO_RES};
    stim_q = {stim_q, bt};
    beats_queued++;
  endtask

  // random varint groups; now and then one that never terminates in time
  task automatic put_number(input kind_t k, input int unsigned max_bytes);
    logic [DATA_W-1:0] b;
    int unsigned       nbytes;
    bit                overlong;
    overlong = ($urandom_range(0, 9) == 0);
    nbytes = overlong ? max_bytes : $urandom_range(1, max_bytes);
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom_range(0, 127));
      b[CONT_IDX] = (i < nbytes - 1) || overlong;
      push_beat(b, (i == 0) ? k : 3'($urandom));
    end
  endtask

  // unsigned varint of v, optionally with one redundant zero group
  task automatic put_uleb(input kind_t k, input logic [VALUE_W-1:0] v, input bit pad);
    logic [DATA_W-1:0] b;
    bit                first;
    first = 1'b1;
    do begin
      b = {1'b0, v[GROUP_BITS-1:0]};
      v = v >> GROUP_BITS;
      b[CONT_IDX] = (v != '0) || pad;
      push_beat(b, first ? k : 3'($urandom));
      first = 1'b0;
    end while (v != '0);
    if (pad) push_beat(8'h00, 3'($urandom));
  endtask

  task automatic put_text();
    logic [VALUE_W-1:0] zz;
    if ($urandom_range(0, 5) == 0) begin
      zz = $urandom_range(0, 1) ? ({$urandom, $urandom} | 64'd1)
                                : 64'(2 * $urandom_range(0, 1000) + 1);
    end else begin
      zz = ($urandom_range(0, 9) == 0) ? 64'(2 * $urandom_range(7, 40))
                                       : 64'(2 * $urandom_range(0, 6));
    end
    put_uleb(K_STRING, zz, $urandom_range(0, 4) == 0);
    if (!zz[0]) repeat (zz >> 1) push_beat(8'($urandom), 3'($urandom));
  endtask

  task automatic put_fixed(input kind_t k, input int unsigned n);
    for (int i = 0; i < n; i++) push_beat(8'($urandom), (i == 0) ? k : 3'($urandom));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // byte source
  initial begin : byte_feed
    int unsigned pick;
    int unsigned pause;
    bit          rush;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.req_type  = '0;
    rush = 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) stim_q = {stim_q, dir_table[i]};
    beats_queued = 0;
    while (beats_queued < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) push_beat(8'($urandom), REQ_UNKNOWN);
      else if (pick < 22) put_number(K_LONG, 32'(LONG_VARINT_BYTES));
      else if (pick < 36) put_number(K_INT, 32'(INT_VARINT_BYTES));
      else if (pick < 46) put_number(K_RAW, 32'(LONG_VARINT_BYTES));
      else if (pick < 54) put_fixed(K_FLOAT, 32'(FLOAT_BYTES));
      else if (pick < 62) put_fixed(K_DOUBLE, 32'(DOUBLE_BYTES));
      else if (pick < 72)
        push_beat($urandom_range(0, 2) == 2 ? 8'($urandom) : 8'($urandom_range(0, 1)), K_BOOL);
      else put_text();
    end
    // longest legal length, left open at the end of the run
    put_uleb(K_STRING, 64'hffff_ffff_ffff_fffe, 1'b0);
    repeat (5) push_beat(8'($urandom), 3'($urandom));

    wait (rst_n === 1'b1);
    @(negedge clk);
    while (stim_q.size() != 0) begin
      if ($urandom_range(0, 19) == 0) rush = !rush;
      pause = rush ? 0 : $urandom_range(0, 13);
      if (pause != 0) begin
        in_ch.valid <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      cur_beat = stim_q.pop_front();
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= cur_beat.data;
      in_ch.req_type  <= cur_beat.req;
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;
    feed_done = 1'b1;
  end

  // result sink, with one long hold-off to back the block up
  initial begin : result_sink
    int unsigned pause;
    bit          rush;
    bit          held;
    out_ch.ready = 1'b0;
    rush = 1'b0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) rush = !rush;
      pause = rush ? 0 : $urandom_range(0, 13);
      if (!held && results_taken >= HOLD_AFTER) begin
        pause = LONG_HOLD;
        held  = 1'b1;
      end
      if (pause != 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin : monitor
    result_t pred;
    result_t want;
    bit      has;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        has = decode_byte(in_ch.data_byte, in_ch.req_type, pred);
        beats_in++;
        case (cur_beat.chk)
          CHK_MODEL: if (has) expected_results = {expected_results, pred};
          CHK_TYPED: expected_results = {expected_results, cur_beat.typed};
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        results_taken++;
        if (out_ch.result_kind <= R_NEGLEN) kind_seen[out_ch.result_kind]++;
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d value %h",
                                  out_ch.result_kind, out_ch.value_bits));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.value_bits !== want.value_bits)
            flag_mismatch($sformatf("value_bits %h, want %h",
                                    out_ch.value_bits, want.value_bits));
          if (out_ch.result_kind !== want.result_kind)
            flag_mismatch($sformatf("result_kind %0d, want %0d",
                                    out_ch.result_kind, want.result_kind));
          if (out_ch.last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", out_ch.last, want.last));
        end
      end
    end else begin
      dec_phase = PH_IDLE;
      dec_kind  = K_LONG;
      dec_acc   = '0;
      dec_pos   = '0;
      dec_left  = '0;
    end
  end

  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no beat for %0d cycles, %0d results outstanding",
                 quiet, expected_results.size());
        $display("avro_primitive_decoder verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    while (!(feed_done && expected_results.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("run covered %0d input beats and %0d checked results", beats_in, results_taken);
    $display("  values %0d, lengths %0d, payload %0d, overlong %0d, negative length %0d",
             kind_seen[R_VALUE], kind_seen[R_LENGTH], kind_seen[R_PAYLOAD],
             kind_seen[R_TOOLONG], kind_seen[R_NEGLEN]);
    if (err_count == 0)
      $display("avro_primitive_decoder verification clean");
    else
      $display("avro_primitive_decoder verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/apd_pkg.sv
rtl/core/apd_in_if.sv
rtl/core/apd_out_if.sv
rtl/core/avro_primitive_decoder.sv
test/avro_primitive_decoder_test.sv
